// File: rtl/obm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_pkg
// Shared types and constants of the order book matcher.
// ----------------------------------------------------------------------------
package obm_pkg;

  localparam int PRICE_W = 24;
  localparam int QTY_W   = 16;
  localparam int USER_W  = 4;
  localparam int CASH_W  = 48;
  localparam int TOK_W   = 32;
  localparam int COST_W  = PRICE_W + QTY_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CASH_W;

  localparam logic [CASH_W-1:0] CASH_RESET = CASH_W'(10000000);
  localparam logic [TOK_W-1:0]  TOK_RESET  = TOK_W'(500);
  localparam logic [CASH_W-1:0] CASH_MAX   = {CASH_W{1'b1}};
  localparam logic [TOK_W-1:0]  TOK_MAX    = {TOK_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_START_CASH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TOK  = 1'b1;

  localparam logic [1:0] CODE_OK       = 2'd0;
  localparam logic [1:0] CODE_NO_CASH  = 2'd1;
  localparam logic [1:0] CODE_NO_TOK   = 2'd2;
  localparam logic [1:0] CODE_FULL     = 2'd3;

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Classified order as it sits in the queue.
  typedef struct packed {
    logic [USER_W-1:0]  user;
    logic               sell;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [COST_W-1:0]  cost;
    logic               user_ok;
  } order_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         code;
    logic [USER_W-1:0]  buyer;
    logic [USER_W-1:0]  seller;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] bid;
    logic [PRICE_W-1:0] ask;
    logic               last;
  } rec_t;

  // Commands into one side of the book.
  typedef struct packed {
    logic               ins;
    logic               upd;
    logic               pop;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [USER_W-1:0]  owner;
    logic [QTY_W-1:0]   new_qty;
  } side_ctl_t;

  // Head of one side of the book.
  typedef struct packed {
    logic               vld;
    logic               full;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [USER_W-1:0]  owner;
  } side_top_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_MATCH, ST_T1, ST_T2, ST_T3, ST_STATUS
  } state_t;

endpackage

// File: rtl/obm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_fifo
// Short queue between the order front end and the matching back end.
// ----------------------------------------------------------------------------
module obm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty,
  output logic         full
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

// File: rtl/obm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_front
// Accepts orders, works out the escrow cost and the wallet index check, and
// queues the classified order for the back end.
// ----------------------------------------------------------------------------
module obm_front
  import obm_pkg::*;
#(
  parameter int NUM_USERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [USER_W-1:0]  in_user_id,
  input  logic               in_mode,
  input  logic [PRICE_W-1:0] in_limit_price,
  input  logic [QTY_W-1:0]   in_quantity,
  input  logic               q_pop,
  output order_t             q_head,
  output logic               q_empty
);
  order_t stg_r;
  logic   stg_vld_r;
  logic   q_full, push, take;

  assign push     = stg_vld_r && !q_full;
  assign in_stall = stg_vld_r && q_full;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (take) begin
      stg_r.user    <= in_user_id;
      stg_r.sell    <= in_mode;
      stg_r.price   <= in_limit_price;
      stg_r.qty     <= in_quantity;
      stg_r.cost    <= COST_W'(in_limit_price) * COST_W'(in_quantity);
      stg_r.user_ok <= (32'(in_user_id) < NUM_USERS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (take) begin
      stg_vld_r <= 1'b1;
    end else if (push) begin
      stg_vld_r <= 1'b0;
    end
  end

  obm_fifo #(.W($bits(order_t)), .DEPTH(2)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (stg_r),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty),
    .full  (q_full)
  );
endmodule

// File: rtl/obm_side.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_side
// One price-sorted side of the book, kept as a shifting register file with
// the best order always at entry 0.
// ----------------------------------------------------------------------------
module obm_side
  import obm_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter bit IS_ASK = 1'b0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  side_ctl_t ctl,
  output side_top_t top
);
  logic [PRICE_W-1:0] price_r [DEPTH];
  logic [QTY_W-1:0]   qty_r   [DEPTH];
  logic [USER_W-1:0]  own_r   [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  logic [DEPTH-1:0]   bef;

  // An entry stays ahead of a new order if it is better or equal in price.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (IS_ASK) begin
        bef[i] = vld_r[i] && (price_r[i] <= ctl.price);
      end else begin
        bef[i] = vld_r[i] && (price_r[i] >= ctl.price);
      end
    end
  end

  assign top.vld   = vld_r[0];
  assign top.full  = vld_r[DEPTH-1];
  assign top.price = price_r[0];
  assign top.qty   = qty_r[0];
  assign top.owner = own_r[0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (ctl.ins && !bef[i]) begin
        if (i == 0 || bef[(i == 0) ? 0 : i-1]) begin
          price_r[i] <= ctl.price;
          qty_r[i]   <= ctl.qty;
          own_r[i]   <= ctl.owner;
        end else begin
          price_r[i] <= price_r[(i == 0) ? 0 : i-1];
          qty_r[i]   <= qty_r[(i == 0) ? 0 : i-1];
          own_r[i]   <= own_r[(i == 0) ? 0 : i-1];
        end
      end else if (ctl.pop && i < DEPTH-1) begin
        price_r[i] <= price_r[(i < DEPTH-1) ? i+1 : i];
        qty_r[i]   <= qty_r[(i < DEPTH-1) ? i+1 : i];
        own_r[i]   <= own_r[(i < DEPTH-1) ? i+1 : i];
      end else if (ctl.upd && i == 0) begin
        qty_r[i] <= ctl.new_qty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.ins) begin
      vld_r <= {vld_r[DEPTH-2:0], 1'b1};
    end else if (ctl.pop) begin
      vld_r <= {1'b0, vld_r[DEPTH-1:1]};
    end
  end
endmodule

// File: rtl/obm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_back
// Carries out queued orders: wallet escrow, book insert, the matching loop
// with wallet settlement, and the trade and status records.
// ----------------------------------------------------------------------------
module obm_back
  import obm_pkg::*;
#(
  parameter int BOOK_DEPTH = 16,
  parameter int NUM_USERS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  order_t                q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rec_t                  out_rec
);
  localparam int UW = $clog2(NUM_USERS);

  state_t state_r, state_nxt;

  logic [CASH_W-1:0] start_cash_r;
  logic [TOK_W-1:0]  start_tok_r;

  // Wallet memories; an entry not written since the last load reads as the
  // start value.
  logic [CASH_W-1:0]    cash_mem [NUM_USERS];
  logic [TOK_W-1:0]     tok_mem  [NUM_USERS];
  logic [NUM_USERS-1:0] cash_vld_r, tok_vld_r;
  logic [CASH_W-1:0]    cash_rd_r;
  logic [TOK_W-1:0]     tok_rd_r;
  logic                 cash_rv_r, tok_rv_r;

  logic              cash_re, cash_we, tok_re, tok_we;
  logic [UW-1:0]     cash_ra, cash_wa, tok_ra, tok_wa;
  logic [CASH_W-1:0] cash_wd;
  logic [TOK_W-1:0]  tok_wd;

  order_t            ord_r;
  logic [1:0]        code_r, code_nxt;
  logic [QTY_W-1:0]  tq_r;
  logic [PRICE_W-1:0] tp_r;
  logic [USER_W-1:0] bo_r, so_r;
  logic [COST_W-1:0] prod_s_r, prod_b_r;

  side_ctl_t bid_ctl, ask_ctl;
  side_top_t bid_top, ask_top;

  rec_t out_r, rec_nxt;
  logic out_vld_r, out_free, out_load;

  logic [CASH_W-1:0] bal_c;
  logic [TOK_W-1:0]  tok_c;
  logic              crossed;
  logic [QTY_W-1:0]  tq_c;
  logic [CASH_W:0]   cash_sum;
  logic [TOK_W:0]    tok_sum;

  assign out_free  = !out_vld_r || !out_stall;
  assign out_valid = out_vld_r;
  assign out_rec   = out_r;

  assign bal_c   = cash_rv_r ? cash_rd_r : start_cash_r;
  assign tok_c   = tok_rv_r ? tok_rd_r : start_tok_r;
  assign crossed = bid_top.vld && ask_top.vld && (bid_top.price >= ask_top.price);
  assign tq_c    = (bid_top.qty < ask_top.qty) ? bid_top.qty : ask_top.qty;

  obm_side #(.DEPTH(BOOK_DEPTH), .IS_ASK(1'b0)) u_bid (
    .clk(clk), .rst_n(rst_n), .ctl(bid_ctl), .top(bid_top)
  );
  obm_side #(.DEPTH(BOOK_DEPTH), .IS_ASK(1'b1)) u_ask (
    .clk(clk), .rst_n(rst_n), .ctl(ask_ctl), .top(ask_top)
  );

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    q_pop     = 1'b0;
    cash_re   = 1'b0;
    cash_we   = 1'b0;
    tok_re    = 1'b0;
    tok_we    = 1'b0;
    cash_ra   = UW'(q_head.user);
    tok_ra    = UW'(q_head.user);
    cash_wa   = UW'(ord_r.user);
    tok_wa    = UW'(ord_r.user);
    cash_wd   = bal_c - CASH_W'(ord_r.cost);
    tok_wd    = tok_c - TOK_W'(ord_r.qty);
    cash_sum  = {1'b0, bal_c} + (CASH_W + 1)'(prod_s_r);
    tok_sum   = {1'b0, tok_c} + (TOK_W + 1)'(tq_r);
    out_load  = 1'b0;
    rec_nxt   = '0;
    bid_ctl   = '0;
    ask_ctl   = '0;
    bid_ctl.price   = ord_r.price;
    bid_ctl.qty     = ord_r.qty;
    bid_ctl.owner   = ord_r.user;
    bid_ctl.new_qty = bid_top.qty - tq_c;
    ask_ctl.price   = ord_r.price;
    ask_ctl.qty     = ord_r.qty;
    ask_ctl.owner   = ord_r.user;
    ask_ctl.new_qty = ask_top.qty - tq_c;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cash_re   = 1'b1;
          tok_re    = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!ord_r.sell) begin
          if (!ord_r.user_ok || bal_c < CASH_W'(ord_r.cost)) begin
            code_nxt = CODE_NO_CASH;
          end else if (bid_top.full) begin
            code_nxt = CODE_FULL;
          end else begin
            code_nxt    = CODE_OK;
            cash_we     = 1'b1;
            bid_ctl.ins = 1'b1;
          end
        end else begin
          if (!ord_r.user_ok || tok_c < TOK_W'(ord_r.qty)) begin
            code_nxt = CODE_NO_TOK;
          end else if (ask_top.full) begin
            code_nxt = CODE_FULL;
          end else begin
            code_nxt    = CODE_OK;
            tok_we      = 1'b1;
            ask_ctl.ins = 1'b1;
          end
        end
        state_nxt = (code_nxt == CODE_OK) ? ST_MATCH : ST_STATUS;
      end
      ST_MATCH: begin
        if (crossed) begin
          cash_re = 1'b1;
          cash_ra = UW'(ask_top.owner);
          tok_re  = 1'b1;
          tok_ra  = UW'(bid_top.owner);
          // An order whose quantity runs out leaves the book.
          bid_ctl.pop = (bid_ctl.new_qty == '0);
          bid_ctl.upd = 1'b1;
          ask_ctl.pop = (ask_ctl.new_qty == '0);
          ask_ctl.upd = 1'b1;
          state_nxt   = ST_T1;
        end else begin
          state_nxt = ST_STATUS;
        end
      end
      ST_T1: begin
        if (out_free) begin
          cash_we  = 1'b1;
          cash_wa  = UW'(so_r);
          cash_wd  = cash_sum[CASH_W] ? CASH_MAX : cash_sum[CASH_W-1:0];
          tok_we   = 1'b1;
          tok_wa   = UW'(bo_r);
          tok_wd   = tok_sum[TOK_W] ? TOK_MAX : tok_sum[TOK_W-1:0];
          out_load = 1'b1;
          rec_nxt.kind   = KIND_TRADE;
          rec_nxt.buyer  = bo_r;
          rec_nxt.seller = so_r;
          rec_nxt.price  = tp_r;
          rec_nxt.qty    = tq_r;
          state_nxt = ST_T2;
        end
      end
      ST_T2: begin
        cash_re   = 1'b1;
        cash_ra   = UW'(bo_r);
        state_nxt = ST_T3;
      end
      ST_T3: begin
        cash_sum  = {1'b0, bal_c} + (CASH_W + 1)'(prod_b_r);
        cash_we   = 1'b1;
        cash_wa   = UW'(bo_r);
        cash_wd   = cash_sum[CASH_W] ? CASH_MAX : cash_sum[CASH_W-1:0];
        state_nxt = ST_MATCH;
      end
      ST_STATUS: begin
        if (out_free) begin
          out_load     = 1'b1;
          rec_nxt.kind = KIND_STATUS;
          rec_nxt.code = code_r;
          rec_nxt.bid  = bid_top.vld ? bid_top.price : '0;
          rec_nxt.ask  = ask_top.vld ? ask_top.price : '0;
          rec_nxt.last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      code_r       <= CODE_OK;
      out_vld_r    <= 1'b0;
      start_cash_r <= CASH_RESET;
      start_tok_r  <= TOK_RESET;
      cash_vld_r   <= '0;
      tok_vld_r    <= '0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      // A start value write reloads every wallet at once.
      if (cfg_wr_en && cfg_index == CFG_START_CASH) begin
        start_cash_r <= cfg_wdata;
        cash_vld_r   <= '0;
      end else if (cash_we) begin
        cash_vld_r[cash_wa] <= 1'b1;
      end
      if (cfg_wr_en && cfg_index == CFG_START_TOK) begin
        start_tok_r <= cfg_wdata[TOK_W-1:0];
        tok_vld_r   <= '0;
      end else if (tok_we) begin
        tok_vld_r[tok_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cash_we) begin
      cash_mem[cash_wa] <= cash_wd;
    end
    if (cash_re) begin
      cash_rd_r <= cash_mem[cash_ra];
      cash_rv_r <= cash_vld_r[cash_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (tok_we) begin
      tok_mem[tok_wa] <= tok_wd;
    end
    if (tok_re) begin
      tok_rd_r <= tok_mem[tok_ra];
      tok_rv_r <= tok_vld_r[tok_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ord_r <= q_head;
    end
    if (state_r == ST_MATCH) begin
      tq_r     <= tq_c;
      tp_r     <= ask_top.price;
      bo_r     <= bid_top.owner;
      so_r     <= ask_top.owner;
      prod_s_r <= COST_W'(ask_top.price) * COST_W'(tq_c);
      prod_b_r <= COST_W'(bid_top.price - ask_top.price) * COST_W'(tq_c);
    end
    if (out_load) begin
      out_r <= rec_nxt;
    end
  end
endmodule

// File: rtl/order_book_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_matcher_unit
// Limit order book matcher with escrowed wallets.
// ----------------------------------------------------------------------------
// Each order item is classified in a front stage (escrow cost, wallet index
// check) and queued, then executed by a sequencer that owns the book and the
// wallet memories. An order yields zero or more trade items followed by one
// status item. A rejected order goes from the check straight to its status
// item; an accepted order enters the book and then matches trade by trade.
// Each trade uses the cash memory for two read-modify-write passes, first
// for the seller and then for the buyer. The book sides shift on insert and
// on removal of the top order. A start value write reloads every wallet at
// once and must be made while no order is in flight.
// ----------------------------------------------------------------------------
module order_book_matcher_unit
  import obm_pkg::*;
#(
  parameter int BOOK_DEPTH = 16,
  parameter int NUM_USERS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [USER_W-1:0]     in_user_id,
  input  logic                  in_mode,
  input  logic [PRICE_W-1:0]    in_limit_price,
  input  logic [QTY_W-1:0]      in_quantity,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_item_kind,
  output logic [1:0]            out_status_code,
  output logic [USER_W-1:0]     out_buyer_id,
  output logic [USER_W-1:0]     out_seller_id,
  output logic [PRICE_W-1:0]    out_trade_price,
  output logic [QTY_W-1:0]      out_trade_quantity,
  output logic [PRICE_W-1:0]    out_best_bid,
  output logic [PRICE_W-1:0]    out_best_ask,
  output logic                  out_last
);
  order_t q_head;
  logic   q_empty, q_pop;
  rec_t   rec;

  obm_front #(.NUM_USERS(NUM_USERS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_user_id     (in_user_id),
    .in_mode        (in_mode),
    .in_limit_price (in_limit_price),
    .in_quantity    (in_quantity),
    .q_pop          (q_pop),
    .q_head         (q_head),
    .q_empty        (q_empty)
  );

  obm_back #(.BOOK_DEPTH(BOOK_DEPTH), .NUM_USERS(NUM_USERS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rec   (rec)
  );

  assign out_item_kind      = rec.kind;
  assign out_status_code    = rec.code;
  assign out_buyer_id       = rec.buyer;
  assign out_seller_id      = rec.seller;
  assign out_trade_price    = rec.price;
  assign out_trade_quantity = rec.qty;
  assign out_best_bid       = rec.bid;
  assign out_best_ask       = rec.ask;
  assign out_last           = rec.last;
endmodule

// File: tb/sv/obm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_checker
// Watches the order and result channels of the order book matcher, keeps its
// own copy of the book and the wallets, and compares every result item with
// the expected one.
// ----------------------------------------------------------------------------
module obm_checker
  import obm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [USER_W-1:0]     in_user_id,
  input  logic                  in_mode,
  input  logic [PRICE_W-1:0]    in_limit_price,
  input  logic [QTY_W-1:0]      in_quantity,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_item_kind,
  input  logic [1:0]            out_status_code,
  input  logic [USER_W-1:0]     out_buyer_id,
  input  logic [USER_W-1:0]     out_seller_id,
  input  logic [PRICE_W-1:0]    out_trade_price,
  input  logic [QTY_W-1:0]      out_trade_quantity,
  input  logic [PRICE_W-1:0]    out_best_bid,
  input  logic [PRICE_W-1:0]    out_best_ask,
  input  logic                  out_last,
  output int                    mismatch_count,
  output int                    pending_count
);

  localparam int DEPTH = 16;
  localparam int USERS = 16;

  logic [PRICE_W-1:0] bid_px [DEPTH];
  logic [QTY_W-1:0]   bid_qt [DEPTH];
  logic [USER_W-1:0]  bid_ow [DEPTH];
  int                 n_bids;
  logic [PRICE_W-1:0] ask_px [DEPTH];
  logic [QTY_W-1:0]   ask_qt [DEPTH];
  logic [USER_W-1:0]  ask_ow [DEPTH];
  int                 n_asks;
  logic [CASH_W-1:0]  cash [USERS];
  logic [TOK_W-1:0]   tokens [USERS];
  rec_t               expected_recs [$];

  assign pending_count = expected_recs.size();

  function automatic logic [CASH_W-1:0] cash_add(logic [CASH_W-1:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {17'd0, a} + {1'b0, b};
    return (s > {17'd0, CASH_MAX}) ? CASH_MAX : s[CASH_W-1:0];
  endfunction

  // Adds one expected item at the tail of the queue.
  task automatic append_rec(rec_t r);
    expected_recs.insert(expected_recs.size(), r);
  endtask

  // Applies one order to the shadow book and queues the items it causes.
  task automatic execute_order(logic [USER_W-1:0] user, logic sell,
                               logic [PRICE_W-1:0] px, logic [QTY_W-1:0] qty);
    logic [1:0]  code;
    logic [63:0] cost;
    int          pos;
    rec_t        r;
    logic [QTY_W-1:0] tq;
    logic [PRICE_W-1:0] tp, bp;
    logic [USER_W-1:0] b, s;
    logic [32:0] tsum;
    code = CODE_OK;
    cost = 64'(px) * 64'(qty);
    if (!sell) begin
      if (cash[user] < cost) code = CODE_NO_CASH;
      else if (n_bids >= DEPTH) code = CODE_FULL;
      else begin
        cash[user] = cash[user] - cost[CASH_W-1:0];
        pos = 0;
        while (pos < n_bids && bid_px[pos] >= px) pos++;
        for (int i = n_bids; i > pos; i--) begin
          bid_px[i] = bid_px[i-1]; bid_qt[i] = bid_qt[i-1]; bid_ow[i] = bid_ow[i-1];
        end
        bid_px[pos] = px; bid_qt[pos] = qty; bid_ow[pos] = user;
        n_bids++;
      end
    end else begin
      if (tokens[user] < 32'(qty)) code = CODE_NO_TOK;
      else if (n_asks >= DEPTH) code = CODE_FULL;
      else begin
        tokens[user] = tokens[user] - 32'(qty);
        pos = 0;
        while (pos < n_asks && ask_px[pos] <= px) pos++;
        for (int i = n_asks; i > pos; i--) begin
          ask_px[i] = ask_px[i-1]; ask_qt[i] = ask_qt[i-1]; ask_ow[i] = ask_ow[i-1];
        end
        ask_px[pos] = px; ask_qt[pos] = qty; ask_ow[pos] = user;
        n_asks++;
      end
    end
    if (code == CODE_OK) begin
      for (int t = 0; t < DEPTH; t++) begin
        if (!(n_bids > 0 && n_asks > 0 && bid_px[0] >= ask_px[0])) break;
        tq = (bid_qt[0] < ask_qt[0]) ? bid_qt[0] : ask_qt[0];
        tp = ask_px[0];
        bp = bid_px[0];
        b = bid_ow[0];
        s = ask_ow[0];
        tsum = {1'b0, tokens[b]} + 33'(tq);
        tokens[b] = tsum[32] ? TOK_MAX : tsum[TOK_W-1:0];
        cash[s] = cash_add(cash[s], 64'(tp) * 64'(tq));
        cash[b] = cash_add(cash[b], 64'(bp - tp) * 64'(tq));
        r = '0;
        r.kind = KIND_TRADE; r.buyer = b; r.seller = s; r.price = tp; r.qty = tq;
        append_rec(r);
        bid_qt[0] = bid_qt[0] - tq;
        ask_qt[0] = ask_qt[0] - tq;
        if (bid_qt[0] == 0) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            bid_px[i] = bid_px[i+1]; bid_qt[i] = bid_qt[i+1]; bid_ow[i] = bid_ow[i+1];
          end
          n_bids--;
        end
        if (ask_qt[0] == 0) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            ask_px[i] = ask_px[i+1]; ask_qt[i] = ask_qt[i+1]; ask_ow[i] = ask_ow[i+1];
          end
          n_asks--;
        end
      end
    end
    r = '0;
    r.kind = KIND_STATUS;
    r.code = code;
    r.bid = (n_bids > 0) ? bid_px[0] : '0;
    r.ask = (n_asks > 0) ? ask_px[0] : '0;
    r.last = 1'b1;
    append_rec(r);
  endtask

  always @(posedge clk) begin
    rec_t got, want;
    if (!rst_n) begin
      n_bids = 0;
      n_asks = 0;
      for (int i = 0; i < USERS; i++) begin
        cash[i] = CASH_RESET;
        tokens[i] = TOK_RESET;
      end
      expected_recs.delete();
      mismatch_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        for (int i = 0; i < USERS; i++) begin
          if (cfg_index == CFG_START_CASH) cash[i] = cfg_wdata[CASH_W-1:0];
          else tokens[i] = cfg_wdata[TOK_W-1:0];
        end
      end
      if (out_valid && !out_stall) begin
        got = '{out_item_kind, out_status_code, out_buyer_id, out_seller_id,
                out_trade_price, out_trade_quantity, out_best_bid, out_best_ask,
                out_last};
        if (expected_recs.size() == 0) begin
          if (mismatch_count < 10)
            $display("ERROR: unexpected result item %p", got);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_recs.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display("ERROR: result mismatch\n  expected %p\n  actual   %p", want, got);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        execute_order(in_user_id, in_mode, in_limit_price, in_quantity);
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives orders and start balance writes into the order book matcher, with
// random idle cycles on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import obm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_CASH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [USER_W-1:0]     in_user_id = '0;
  logic                  in_mode = 1'b0;
  logic [PRICE_W-1:0]    in_limit_price = '0;
  logic [QTY_W-1:0]      in_quantity = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_item_kind;
  logic [1:0]            out_status_code;
  logic [USER_W-1:0]     out_buyer_id, out_seller_id;
  logic [PRICE_W-1:0]    out_trade_price, out_best_bid, out_best_ask;
  logic [QTY_W-1:0]      out_trade_quantity;
  logic                  out_last;
  int                    mismatch_count, pending_count;
  int                    sender_idle_pct = 0;
  int                    receiver_idle_pct = 0;
  int                    cycle_count = 0;

  always #6 clk = ~clk;

  order_book_matcher_unit u_dut (.*);
  obm_checker u_checker (.*);

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Valid stays high after an accepted item unless an idle cycle follows.
  task automatic place_order(logic [USER_W-1:0] user, logic sell,
                             logic [PRICE_W-1:0] px, logic [QTY_W-1:0] qty);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_user_id <= user;
    in_mode <= sell;
    in_limit_price <= px;
    in_quantity <= qty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_start(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly prices around a small center so that orders cross and trade.
  task automatic random_orders(int count);
    logic [PRICE_W-1:0] px;
    logic [QTY_W-1:0]   qty;
    for (int i = 0; i < count; i++) begin
      px = ($urandom_range(9) == 0) ? PRICE_W'($urandom) : PRICE_W'(1000 + $urandom_range(40));
      qty = ($urandom_range(9) == 0) ? QTY_W'($urandom) : QTY_W'($urandom_range(60));
      place_order(USER_W'($urandom), 1'($urandom), px, qty);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 10;
    receiver_idle_pct = 75;

    // Directed: rejects, zero quantity, equal prices, extremes, book full.
    place_order(4'd0, 1'b0, 24'hFFFFFF, 16'hFFFF);
    place_order(4'd1, 1'b1, 24'd100, 16'hFFFF);
    place_order(4'd2, 1'b0, 24'd0, 16'd0);
    place_order(4'd3, 1'b1, 24'd0, 16'd0);
    place_order(4'd4, 1'b1, 24'd500, 16'd10);
    place_order(4'd5, 1'b1, 24'd500, 16'd20);
    place_order(4'd6, 1'b0, 24'd600, 16'd25);
    place_order(4'd15, 1'b0, 24'd400, 16'd1);
    for (int i = 0; i < 16; i++) place_order(4'(i), 1'b1, 24'hFFFFF0 + 24'(i), 16'd1);
    wait_drained();

    write_start(CFG_START_CASH, CASH_MAX);
    write_start(CFG_START_TOK, TOK_MAX);
    place_order(4'd7, 1'b0, 24'hFFFFFF, 16'hFFFF);
    place_order(4'd8, 1'b0, 24'hFFFFFF, 16'hFFFF);
    wait_drained();

    write_start(CFG_START_CASH, '0);
    write_start(CFG_START_TOK, '0);
    place_order(4'd9, 1'b0, 24'd1, 16'd1);
    place_order(4'd9, 1'b1, 24'd1, 16'd1);
    wait_drained();

    write_start(CFG_START_CASH, 48'd10000000);
    write_start(CFG_START_TOK, 32'd500);
    random_orders(28);
    wait_drained();
    sender_idle_pct = 75;
    receiver_idle_pct = 10;
    random_orders(27);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    random_orders(27);

    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: order_book_matcher_unit.f
rtl/obm_pkg.sv
rtl/obm_fifo.sv
rtl/obm_front.sv
rtl/obm_side.sv
rtl/obm_back.sv
rtl/order_book_matcher_unit.sv
tb/sv/obm_checker.sv
tb/sv/testbench.sv
